FILE: rtl/diw_pkg.sv
// diw_pkg: shared types, codes and descriptor tables for the descriptor image walker
// used by diw_walk and descriptor_image_walker_core; no dependencies
package diw_pkg;

	localparam int HEADER_BYTES_DEF = 12;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DESC   = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SHORT     = 3'd1;
	localparam logic [2:0] ERR_VERSION   = 3'd2;
	localparam logic [2:0] ERR_HDR_NAME  = 3'd3;
	localparam logic [2:0] ERR_TYPE      = 3'd4;
	localparam logic [2:0] ERR_TRUNC     = 3'd5;
	localparam logic [2:0] ERR_DESC_NAME = 3'd6;
	localparam logic [2:0] ERR_LONG      = 3'd7;

	localparam logic [2:0] TYPE_NONE  = 3'd0;
	localparam logic [2:0] TYPE_GROUP = 3'd1;
	localparam logic [2:0] TYPE_POWER = 3'd2;
	localparam logic [2:0] TYPE_DATA  = 3'd3;
	localparam logic [2:0] TYPE_IOPIN = 3'd4;
	localparam logic [2:0] TYPE_UART  = 3'd5;
	localparam logic [2:0] TYPE_I2C   = 3'd6;
	localparam logic [2:0] TYPE_SPI   = 3'd7;

	localparam logic [7:0] VERSION_BYTE = 8'h01;
	localparam logic [7:0] FILL_BYTE    = 8'hff;
	localparam logic [7:0] OFFSET_LIMIT = 8'hff;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] err;
		logic [2:0] dtype;
		logic [7:0] offset;
		logic [8:0] body;
		logic [7:0] nlen;
		logic [7:0] goff;
		logic       in_grp;
		logic       last;
	} record_t;

	typedef struct packed {
		logic [1:0] count;
		record_t    rec0;
		record_t    rec1;
	} push_t;

	// body bytes still to come after the type byte
	function automatic logic [8:0] body_init(input logic [2:0] t);
		logic [8:0] r;
		case (t)
			TYPE_GROUP: r = 9'd0;
			TYPE_POWER: r = 9'd4;
			TYPE_DATA:  r = 9'd1;
			TYPE_IOPIN: r = 9'd1;
			TYPE_UART:  r = 9'd3;
			TYPE_I2C:   r = 9'd2;
			TYPE_SPI:   r = 9'd2;
			default:    r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic name_default(input logic [2:0] t);
		logic r;
		case (t)
			TYPE_NONE:  r = 1'b0;
			TYPE_POWER: r = 1'b0;
			default:    r = 1'b1;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/diw_walk.sv
// diw_walk: byte delay, header check and descriptor walk state for one image
// depends on diw_pkg; produces up to two records per item
module diw_walk #(
	parameter int HEADER_BYTES = diw_pkg::HEADER_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	output diw_pkg::push_t  push
);

	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_HFIX    = 3'd1,
		PH_HNAME   = 3'd2,
		PH_IDLE    = 3'd3,
		PH_BODY    = 3'd4,
		PH_DNAME   = 3'd5
	} phase_t;

	localparam logic [7:0] HFIX_END = 8'(HEADER_BYTES - 1);
	localparam logic [8:0] HDR_LEN = 9'(HEADER_BYTES);

	logic       dv0_q, dv1_q, dv0_d, dv1_d;
	logic [7:0] d0_q, d1_q, d0_d, d1_d;
	logic [7:0] pos_q, pos_d;
	phase_t     phase_q, phase_d;
	logic [2:0] type_q, type_d;
	logic [7:0] start_q, start_d;
	logic [8:0] br_q, br_d;
	logic       nw_q, nw_d;
	logic [7:0] nc_q, nc_d;
	logic [7:0] gstart_q, gstart_d;
	logic       gseen_q, gseen_d;
	logic       failed_q, failed_d;

	logic [7:0] b;
	logic [7:0] rel;
	logic [7:0] nc_inc;
	logic [8:0] br_t, br_n;
	logic       nw_t;
	logic [7:0] fin_nc;
	logic [8:0] fin_body;
	diw_pkg::record_t fin_rec, rec_p, rec_l;
	logic       p_emit, l_emit;

	assign b      = d0_q;
	assign rel    = pos_q - start_q;
	assign nc_inc = nc_q + 8'd1;
	assign fin_nc = (phase_q == PH_DNAME) ? nc_inc : 8'd0;
	assign fin_body = {1'b0, pos_q} + 9'd1 - {1'b0, start_q} - {1'b0, fin_nc};

	always_comb begin
		fin_rec = '0;
		fin_rec.kind   = diw_pkg::KIND_DESC;
		fin_rec.err    = diw_pkg::ERR_NONE;
		fin_rec.dtype  = type_q;
		fin_rec.offset = start_q;
		fin_rec.body   = fin_body;
		fin_rec.nlen   = fin_nc;
		if (type_q == diw_pkg::TYPE_GROUP) begin
			fin_rec.goff   = start_q;
			fin_rec.in_grp = 1'b0;
		end else begin
			fin_rec.goff   = gseen_q ? gstart_q : 8'd0;
			fin_rec.in_grp = gseen_q;
		end
		fin_rec.last = 1'b0;
	end

	// data length and name-present bits picked up in the body
	always_comb begin
		br_t = br_q;
		nw_t = nw_q;
		if (rel == 8'd1 && type_q == diw_pkg::TYPE_DATA) begin
			br_t = br_q + {1'b0, b};
			nw_t = b[7];
		end else if (rel == 8'd1 && (type_q == diw_pkg::TYPE_I2C ||
				type_q == diw_pkg::TYPE_SPI)) begin
			nw_t = b[7];
		end else if (rel == 8'd3 && type_q == diw_pkg::TYPE_UART) begin
			nw_t = b[7];
		end
		br_n = (br_t != 9'd0) ? br_t - 9'd1 : 9'd0;
	end

	always_comb begin
		dv0_d    = dv1_q;
		d0_d     = d1_q;
		dv1_d    = 1'b1;
		d1_d     = data_byte;
		pos_d    = pos_q;
		phase_d  = phase_q;
		type_d   = type_q;
		start_d  = start_q;
		br_d     = br_q;
		nw_d     = nw_q;
		nc_d     = nc_q;
		gstart_d = gstart_q;
		gseen_d  = gseen_q;
		failed_d = failed_q;
		rec_p    = '0;
		rec_l    = '0;
		p_emit   = 1'b0;
		l_emit   = 1'b0;

		if (dv0_q && dv1_q && !failed_q) begin
			if (pos_q == diw_pkg::OFFSET_LIMIT) begin
				p_emit     = 1'b1;
				failed_d   = 1'b1;
				rec_p.kind = diw_pkg::KIND_ERROR;
				rec_p.err  = diw_pkg::ERR_LONG;
				rec_p.last = 1'b1;
			end else begin
				pos_d = pos_q + 8'd1;
				case (phase_q)
					PH_VERSION: begin
						if (b != diw_pkg::VERSION_BYTE) begin
							p_emit     = 1'b1;
							failed_d   = 1'b1;
							rec_p.kind = diw_pkg::KIND_ERROR;
							rec_p.err  = diw_pkg::ERR_VERSION;
							rec_p.last = 1'b1;
						end else begin
							phase_d = (HEADER_BYTES > 1) ? PH_HFIX : PH_HNAME;
							nc_d    = 8'd0;
						end
					end
					PH_HFIX: begin
						if (pos_q >= HFIX_END) begin
							phase_d = PH_HNAME;
							nc_d    = 8'd0;
						end
					end
					PH_HNAME: begin
						nc_d = nc_inc;
						if (b[7]) begin
							p_emit     = 1'b1;
							rec_p.kind = diw_pkg::KIND_HEADER;
							rec_p.body = HDR_LEN;
							rec_p.nlen = nc_inc;
							phase_d    = PH_IDLE;
						end
					end
					PH_IDLE: begin
						if (b == diw_pkg::FILL_BYTE) begin
							phase_d = PH_IDLE;
						end else if (b == 8'd0 || b > 8'd7) begin
							p_emit       = 1'b1;
							failed_d     = 1'b1;
							rec_p.kind   = diw_pkg::KIND_ERROR;
							rec_p.err    = diw_pkg::ERR_TYPE;
							rec_p.offset = pos_q;
							rec_p.last   = 1'b1;
						end else begin
							start_d = pos_q;
							type_d  = b[2:0];
							br_d    = diw_pkg::body_init(b[2:0]);
							nw_d    = diw_pkg::name_default(b[2:0]);
							nc_d    = 8'd0;
							// a group has no body and always a name
							phase_d = (b[2:0] == diw_pkg::TYPE_GROUP) ? PH_DNAME : PH_BODY;
						end
					end
					PH_BODY: begin
						br_d = br_n;
						nw_d = nw_t;
						if (br_n == 9'd0) begin
							nc_d = 8'd0;
							if (nw_t) begin
								phase_d = PH_DNAME;
							end else begin
								p_emit  = 1'b1;
								rec_p   = fin_rec;
								phase_d = PH_IDLE;
							end
						end
					end
					PH_DNAME: begin
						nc_d = nc_inc;
						if (b[7]) begin
							p_emit  = 1'b1;
							rec_p   = fin_rec;
							phase_d = PH_IDLE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
				if (p_emit && rec_p.kind == diw_pkg::KIND_DESC &&
						type_q == diw_pkg::TYPE_GROUP) begin
					gstart_d = start_q;
					gseen_d  = 1'b1;
				end
			end
		end

		if (last_byte) begin
			if (!failed_d) begin
				l_emit     = 1'b1;
				rec_l.kind = diw_pkg::KIND_ERROR;
				rec_l.last = 1'b1;
				case (phase_d)
					PH_IDLE: rec_l.kind = diw_pkg::KIND_END;
					PH_HNAME: rec_l.err = (nc_d == 8'd0) ? diw_pkg::ERR_SHORT
						: diw_pkg::ERR_HDR_NAME;
					PH_BODY: begin
						rec_l.err    = diw_pkg::ERR_TRUNC;
						rec_l.dtype  = type_d;
						rec_l.offset = start_d;
					end
					PH_DNAME: begin
						rec_l.err    = diw_pkg::ERR_DESC_NAME;
						rec_l.dtype  = type_d;
						rec_l.offset = start_d;
					end
					default: rec_l.err = diw_pkg::ERR_SHORT;
				endcase
			end
			dv0_d    = 1'b0;
			dv1_d    = 1'b0;
			pos_d    = 8'd0;
			phase_d  = PH_VERSION;
			type_d   = 3'd0;
			start_d  = 8'd0;
			br_d     = 9'd0;
			nw_d     = 1'b0;
			nc_d     = 8'd0;
			gstart_d = 8'd0;
			gseen_d  = 1'b0;
			failed_d = 1'b0;
		end
	end

	always_comb begin
		push.count = {1'b0, p_emit} + {1'b0, l_emit};
		push.rec0  = p_emit ? rec_p : rec_l;
		push.rec1  = rec_l;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv0_q    <= 1'b0;
			dv1_q    <= 1'b0;
			pos_q    <= 8'd0;
			phase_q  <= PH_VERSION;
			type_q   <= 3'd0;
			start_q  <= 8'd0;
			br_q     <= 9'd0;
			nw_q     <= 1'b0;
			nc_q     <= 8'd0;
			gstart_q <= 8'd0;
			gseen_q  <= 1'b0;
			failed_q <= 1'b0;
		end else if (fire) begin
			dv0_q    <= dv0_d;
			dv1_q    <= dv1_d;
			pos_q    <= pos_d;
			phase_q  <= phase_d;
			type_q   <= type_d;
			start_q  <= start_d;
			br_q     <= br_d;
			nw_q     <= nw_d;
			nc_q     <= nc_d;
			gstart_q <= gstart_d;
			gseen_q  <= gseen_d;
			failed_q <= failed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			d0_q <= d0_d;
			d1_q <= d1_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_byte |=> !dv0_q && !dv1_q && phase_q == PH_VERSION)
		else $error("walker state not cleared after image end");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && push.count == 2'd2 |-> push.rec1.last && !push.rec0.last)
		else $error("two records in one item with wrong final mark");

	assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> dv0_q && dv1_q)
		else $error("failure recorded without processed byte");

endmodule

FILE: rtl/descriptor_image_walker_core.sv
// descriptor_image_walker_core: top level, input register, walker and result queue
// depends on diw_pkg and diw_walk
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid, in_stall | data_byte, last_byte
//   out     | out_valid, out_stall | record_kind .. last_record, one record per item
//
// one byte is accepted per cycle while in_stall is low; it is walked from the input register
// a byte is parsed when two newer bytes have come in, so its record leaves with a later byte
// records enter a four-entry queue; the input register holds while fewer than two entries are free
// out_valid follows the queue occupancy; a record is queued the cycle after its byte is walked
// reset at once empties the queue and clears the input valid bit and all walker state except the delayed bytes
module descriptor_image_walker_core #(
	parameter int HEADER_BYTES = diw_pkg::HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] record_kind,
	output logic [2:0] error_code,
	output logic [2:0] desc_type,
	output logic [7:0] item_offset,
	output logic [8:0] body_length,
	output logic [7:0] name_len,
	output logic [7:0] group_offset,
	output logic       in_group,
	output logic       last_record
);

	localparam int PW = $clog2(diw_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(diw_pkg::QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FIRE_LIMIT = CW'(diw_pkg::QUEUE_DEPTH - 2);
	localparam logic [CW-1:0] FULL_COUNT = CW'(diw_pkg::QUEUE_DEPTH);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fire, pop;
	diw_pkg::push_t push;

	diw_pkg::record_t queue_q [diw_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wptr_1;
	diw_pkg::record_t head;

	assign fire     = valid_s1 && (count_q <= FIRE_LIMIT);
	assign in_stall = valid_s1 && !fire;
	assign pop      = out_valid && !out_stall;
	assign wptr_1   = wptr_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	diw_walk #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.push      (push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (fire) begin
				wptr_q <= wptr_q + PW'(push.count);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			count_q <= count_q + (fire ? CW'(push.count) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (fire && push.count != 2'd0) begin
			queue_q[wptr_q] <= push.rec0;
		end
		if (fire && push.count == 2'd2) begin
			queue_q[wptr_1] <= push.rec1;
		end
	end

	assign head         = queue_q[rptr_q];
	assign out_valid    = (count_q != '0);
	assign record_kind  = head.kind;
	assign error_code   = head.err;
	assign desc_type    = head.dtype;
	assign item_offset  = head.offset;
	assign body_length  = head.body;
	assign name_len     = head.nlen;
	assign group_offset = head.goff;
	assign in_group     = head.in_grp;
	assign last_record  = head.last;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> count_q <= FIRE_LIMIT)
		else $error("item walked without room for two records");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input held with empty input register");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == diw_pkg::KIND_ERROR |-> last_record)
		else $error("error record not marked final");

endmodule
